// File: src/cps_pkg.sv
`default_nettype none

package cps_pkg;

  // Default build of the smoother
  localparam int unsigned DEF_MAX_PASSES  = 5;
  localparam int unsigned DEF_COORD_WIDTH = 32;

  // Depth of the queue between the front end and the pass cascade
  localparam int unsigned QUEUE_DEPTH = 4;

  // Register port: two 32-bit registers at byte addresses 0 and 4
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;
  localparam int unsigned PASS_CNT_W = 3;

  // Register index, taken from paddr[2]
  localparam logic REG_SMOOTH_EN  = 1'b0;
  localparam logic REG_PASS_COUNT = 1'b1;

  // Register reset values
  localparam logic                  SMOOTH_EN_RESET  = 1'b1;
  localparam logic [PASS_CNT_W-1:0] PASS_COUNT_RESET = 3'd3;

endpackage

`default_nettype wire

// File: src/cps_queue.sv
`default_nettype none

module cps_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = cps_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  input  wire logic [Width-1:0] push_data_i,
  output logic                  push_stall_o,
  output logic                  pop_valid_o,
  output logic      [Width-1:0] pop_data_o,
  input  wire logic             pop_stall_i
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  assign push_stall_o = (count_q == CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  assign push = push_valid_i & ~push_stall_o;
  assign pop  = pop_valid_o & ~pop_stall_i;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming transfer
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(Depth))
    else $error("queue fill count beyond depth");

endmodule

`default_nettype wire

// File: src/cps_front.sv
`default_nettype none

module cps_front #(
  parameter int unsigned MaxPasses  = cps_pkg::DEF_MAX_PASSES,
  parameter int unsigned CoordWidth = cps_pkg::DEF_COORD_WIDTH,
  localparam int unsigned PassW     = $clog2(MaxPasses + 1),
  localparam int unsigned ItemW     = PassW + 1 + 2 * CoordWidth
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // register port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [cps_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [cps_pkg::PDATA_W-1:0]  pwdata,
  output logic      [cps_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  // waypoint input
  input  wire logic                         point_valid_i,
  output logic                              point_stall_o,
  input  wire logic signed [CoordWidth-1:0] point_x_i,
  input  wire logic signed [CoordWidth-1:0] point_y_i,
  input  wire logic                         point_last_i,
  // tagged item toward the queue
  output logic                              item_valid_o,
  output logic      [ItemW-1:0]             item_data_o,
  input  wire logic                         item_stall_i
);

  localparam int unsigned CntW = cps_pkg::PASS_CNT_W;

  logic             smoothing_enable_q;
  logic [CntW-1:0]  pass_count_q;
  logic             cfg_write;
  logic             reg_idx;
  logic [CntW-1:0]  sat_count;
  logic [PassW-1:0] pass_sel;
  logic             accept;
  logic             valid_q, valid_d;
  logic [ItemW-1:0] data_q;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[2];
  assign cfg_write = psel & penable & pwrite;

  // Write the configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smoothing_enable_q <= cps_pkg::SMOOTH_EN_RESET;
      pass_count_q       <= cps_pkg::PASS_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        cps_pkg::REG_SMOOTH_EN:  smoothing_enable_q <= pwdata[0];
        cps_pkg::REG_PASS_COUNT: pass_count_q       <= pwdata[CntW-1:0];
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      cps_pkg::REG_SMOOTH_EN:  prdata[0]      = smoothing_enable_q;
      cps_pkg::REG_PASS_COUNT: prdata[CntW-1:0] = pass_count_q;
    endcase
  end

  // Classify: number of passes this waypoint runs through
  assign sat_count = (pass_count_q > CntW'(MaxPasses)) ? CntW'(MaxPasses) : pass_count_q;
  assign pass_sel  = smoothing_enable_q ? PassW'(sat_count) : '0;

  // Hold the tagged item until the queue takes it
  assign point_stall_o = valid_q & item_stall_i;
  assign accept        = point_valid_i & ~point_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (!item_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= {pass_sel, point_last_i, point_y_i, point_x_i};
    end
  end

  assign item_valid_o = valid_q;
  assign item_data_o  = data_q;

endmodule

`default_nettype wire

// File: src/cps_stage.sv
`default_nettype none

module cps_stage #(
  parameter int unsigned MaxPasses  = cps_pkg::DEF_MAX_PASSES,
  parameter int unsigned CoordWidth = cps_pkg::DEF_COORD_WIDTH,
  parameter int unsigned StageIdx   = 0,
  localparam int unsigned PassW     = $clog2(MaxPasses + 1),
  localparam int unsigned ItemW     = PassW + 1 + 2 * CoordWidth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic [ItemW-1:0] in_data_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  output logic      [ItemW-1:0] out_data_o,
  input  wire logic             out_stall_i
);

  localparam int unsigned W = CoordWidth;

  // floor((3a + p) / 4) on signed coordinates, exact
  function automatic logic [W-1:0] mix31(input logic [W-1:0] a, input logic [W-1:0] p);
    logic signed [W+1:0] sa;
    logic signed [W+1:0] sp;
    logic signed [W+1:0] sum;
    sa  = {{2{a[W-1]}}, a};
    sp  = {{2{p[W-1]}}, p};
    sum = (sa <<< 1) + sa + sp;
    return sum[W+1:2];
  endfunction

  logic [W-1:0]     in_x, in_y;
  logic             in_last;
  logic [PassW-1:0] in_pass;
  logic             active;

  logic [W-1:0]     prev_x_q, prev_y_q;
  logic             has_prev_q, first_seg_q;

  logic [ItemW-1:0] q_item, r_item;
  logic [ItemW-1:0] first_data, second_data;
  logic             second_v;

  logic             out_v_q, out_v_d;
  logic [ItemW-1:0] out_data_q;
  logic             pend_v_q, pend_v_d;
  logic [ItemW-1:0] pend_data_q;
  logic             out_free, accept;

  assign in_x    = in_data_i[W-1:0];
  assign in_y    = in_data_i[2*W-1:W];
  assign in_last = in_data_i[2*W];
  assign in_pass = in_data_i[ItemW-1 -: PassW];
  assign active  = (in_pass > PassW'(StageIdx));

  // Cut points toward the previous and toward the new point
  assign q_item = {in_pass, 1'b0, mix31(prev_y_q, in_y), mix31(prev_x_q, in_x)};
  assign r_item = {in_pass, 1'b0, mix31(in_y, prev_y_q), mix31(in_x, prev_x_q)};

  // Pick the one or two points this item emits
  always_comb begin
    first_data  = in_data_i;
    second_data = in_data_i;
    second_v    = 1'b0;
    if (active && has_prev_q) begin
      if (!first_seg_q) begin
        first_data  = q_item;
        second_data = in_last ? in_data_i : r_item;
        second_v    = 1'b1;
      end else begin
        first_data  = in_last ? in_data_i : r_item;
      end
    end
  end

  // Take a new transfer only when both output slots are free
  assign out_free   = ~out_v_q | ~out_stall_i;
  assign in_stall_o = pend_v_q | ~out_free;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    out_v_d  = out_v_q;
    pend_v_d = pend_v_q;
    if (out_free) begin
      if (pend_v_q) begin
        out_v_d  = 1'b1;
        pend_v_d = 1'b0;
      end else if (accept) begin
        out_v_d  = 1'b1;
        pend_v_d = second_v;
      end else begin
        out_v_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && pend_v_q) begin
      out_data_q <= pend_data_q;
    end else if (accept) begin
      out_data_q <= first_data;
    end
    if (accept) begin
      pend_data_q <= second_data;
    end
  end

  // Track the path in progress through this pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_prev_q  <= 1'b0;
      first_seg_q <= 1'b1;
    end else if (accept && active) begin
      if (!has_prev_q) begin
        has_prev_q  <= ~in_last;
        first_seg_q <= 1'b1;
      end else if (!in_last) begin
        first_seg_q <= 1'b0;
      end else begin
        has_prev_q  <= 1'b0;
        first_seg_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && active && !in_last) begin
      prev_x_q <= in_x;
      prev_y_q <= in_y;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_data_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) pend_v_q |-> out_v_q)
    else $error("second point pending without a first point shown");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !has_prev_q |-> first_seg_q)
    else $error("idle pass stage not armed for a first segment");

  assert property (@(posedge clk_i) disable iff (!rst_ni) (accept && second_v) |=> pend_v_q)
    else $error("second point of a transfer dropped");

endmodule

`default_nettype wire

// File: src/chaikin_path_smoother.sv
`default_nettype none

// Channel    Direction  Handshake                      Payload
// point      in         point_valid_i / point_stall_o  point_x_i, point_y_i, point_last_i
// smooth     out        smooth_valid_o / smooth_stall_i smooth_x_o, smooth_y_o, smooth_last_o
// register   in/out     psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// Each pass stage emits one point per cycle while its output is not stalled; a stage that
// cuts a corner makes two points from one and stalls its input while the second waits. A
// waypoint run through P passes yields up to 2**P results, one per cycle at the last stage
// while smooth_stall_i is low. A lone point passes the front-end register, the queue and
// each stage's output register in turn. Reset clears all handshake and path-tracking state;
// configuration returns to smoothing on with three passes. A stall at the output backs up
// stage by stage into the queue, which keeps accepting waypoints until it is full.

module chaikin_path_smoother #(
  parameter int unsigned MaxPasses  = cps_pkg::DEF_MAX_PASSES,
  parameter int unsigned CoordWidth = cps_pkg::DEF_COORD_WIDTH
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [cps_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [cps_pkg::PDATA_W-1:0]  pwdata,
  output logic      [cps_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  input  wire logic                         point_valid_i,
  output logic                              point_stall_o,
  input  wire logic signed [CoordWidth-1:0] point_x_i,
  input  wire logic signed [CoordWidth-1:0] point_y_i,
  input  wire logic                         point_last_i,
  output logic                              smooth_valid_o,
  input  wire logic                         smooth_stall_i,
  output logic signed [CoordWidth-1:0]      smooth_x_o,
  output logic signed [CoordWidth-1:0]      smooth_y_o,
  output logic                              smooth_last_o
);

  localparam int unsigned PassW = $clog2(MaxPasses + 1);
  localparam int unsigned ItemW = PassW + 1 + 2 * CoordWidth;

  logic             item_valid, item_stall;
  logic [ItemW-1:0] item_data;

  logic             link_valid [MaxPasses+1];
  logic             link_stall [MaxPasses+1];
  logic [ItemW-1:0] link_data  [MaxPasses+1];

  // Front end: register port, classify and hold each waypoint
  cps_front #(
    .MaxPasses (MaxPasses),
    .CoordWidth(CoordWidth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .point_valid_i(point_valid_i),
    .point_stall_o(point_stall_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_last_i (point_last_i),
    .item_valid_o (item_valid),
    .item_data_o  (item_data),
    .item_stall_i (item_stall)
  );

  // Decouple the front end from the pass cascade
  cps_queue #(
    .Width(ItemW),
    .Depth(cps_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(item_valid),
    .push_data_i (item_data),
    .push_stall_o(item_stall),
    .pop_valid_o (link_valid[0]),
    .pop_data_o  (link_data[0]),
    .pop_stall_i (link_stall[0])
  );

  // Back end: one corner-cutting stage per pass
  for (genvar s = 0; s < MaxPasses; s++) begin : g_stage
    cps_stage #(
      .MaxPasses (MaxPasses),
      .CoordWidth(CoordWidth),
      .StageIdx  (s)
    ) u_stage (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (link_valid[s]),
      .in_data_i  (link_data[s]),
      .in_stall_o (link_stall[s]),
      .out_valid_o(link_valid[s+1]),
      .out_data_o (link_data[s+1]),
      .out_stall_i(link_stall[s+1])
    );
  end

  assign link_stall[MaxPasses] = smooth_stall_i;
  assign smooth_valid_o        = link_valid[MaxPasses];
  assign smooth_x_o            = link_data[MaxPasses][CoordWidth-1:0];
  assign smooth_y_o            = link_data[MaxPasses][2*CoordWidth-1:CoordWidth];
  assign smooth_last_o         = link_data[MaxPasses][2*CoordWidth];

endmodule

`default_nettype wire
